>>> hw/rtl/sbox_xorshift_hash128_defines.svh
// Assertion macros for the sbox xorshift hash block.
`ifndef SBOX_XORSHIFT_HASH128_DEFINES_SVH
`define SBOX_XORSHIFT_HASH128_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SXH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sxh assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SXH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sxh assertion failed");

`endif

>>> hw/rtl/sxh_pkg.sv
// Types, constants and round function of the sbox xorshift hash.
package sxh_pkg;

  localparam logic [4:0] SXH_WORD_BYTES = 5'd16;
  localparam int unsigned SXH_ROT_A = 23;
  localparam int unsigned SXH_ROT_B = 17;
  localparam int unsigned SXH_ROT_C = 47;

  localparam logic [7:0] SXH_SBOX [256] = '{
    8'd150, 8'd130, 8'd8, 8'd186, 8'd3, 8'd179, 8'd213, 8'd64, 8'd123, 8'd45, 8'd41,
    8'd99, 8'd250, 8'd175, 8'd48, 8'd7, 8'd226, 8'd97, 8'd177, 8'd185, 8'd191, 8'd108,
    8'd94, 8'd231, 8'd220, 8'd68, 8'd74, 8'd133, 8'd162, 8'd2, 8'd116, 8'd122, 8'd193,
    8'd182, 8'd255, 8'd249, 8'd73, 8'd47, 8'd209, 8'd238, 8'd233, 8'd30, 8'd119, 8'd11,
    8'd245, 8'd154, 8'd54, 8'd136, 8'd21, 8'd85, 8'd225, 8'd232, 8'd203, 8'd10, 8'd5,
    8'd66, 8'd176, 8'd157, 8'd56, 8'd76, 8'd120, 8'd229, 8'd197, 8'd178, 8'd221, 8'd195,
    8'd217, 8'd104, 8'd135, 8'd204, 8'd49, 8'd244, 8'd149, 8'd63, 8'd151, 8'd33, 8'd121,
    8'd77, 8'd196, 8'd95, 8'd242, 8'd215, 8'd67, 8'd251, 8'd212, 8'd101, 8'd254, 8'd23,
    8'd160, 8'd164, 8'd222, 8'd103, 8'd91, 8'd208, 8'd236, 8'd216, 8'd52, 8'd26, 8'd25,
    8'd218, 8'd61, 8'd1, 8'd139, 8'd90, 8'd143, 8'd58, 8'd152, 8'd140, 8'd246, 8'd50,
    8'd159, 8'd31, 8'd207, 8'd53, 8'd147, 8'd0, 8'd84, 8'd80, 8'd35, 8'd155, 8'd106,
    8'd59, 8'd126, 8'd214, 8'd189, 8'd111, 8'd131, 8'd174, 8'd112, 8'd248, 8'd172, 8'd39,
    8'd252, 8'd51, 8'd107, 8'd36, 8'd138, 8'd125, 8'd16, 8'd134, 8'd228, 8'd158, 8'd156,
    8'd57, 8'd62, 8'd93, 8'd148, 8'd6, 8'd70, 8'd29, 8'd190, 8'd15, 8'd241, 8'd200,
    8'd205, 8'd71, 8'd89, 8'd42, 8'd132, 8'd22, 8'd224, 8'd166, 8'd198, 8'd118, 8'd32,
    8'd17, 8'd37, 8'd55, 8'd235, 8'd100, 8'd161, 8'd88, 8'd223, 8'd24, 8'd92, 8'd201,
    8'd113, 8'd12, 8'd243, 8'd173, 8'd14, 8'd27, 8'd34, 8'd183, 8'd247, 8'd86, 8'd75,
    8'd240, 8'd171, 8'd170, 8'd109, 8'd65, 8'd115, 8'd230, 8'd124, 8'd163, 8'd192, 8'd82,
    8'd142, 8'd145, 8'd72, 8'd227, 8'd234, 8'd187, 8'd18, 8'd105, 8'd202, 8'd194, 8'd60,
    8'd4, 8'd79, 8'd199, 8'd117, 8'd40, 8'd165, 8'd127, 8'd46, 8'd69, 8'd114, 8'd102,
    8'd169, 8'd20, 8'd98, 8'd128, 8'd78, 8'd184, 8'd96, 8'd9, 8'd28, 8'd38, 8'd210,
    8'd188, 8'd83, 8'd137, 8'd211, 8'd181, 8'd44, 8'd206, 8'd43, 8'd81, 8'd253, 8'd219,
    8'd153, 8'd239, 8'd146, 8'd167, 8'd168, 8'd87, 8'd129, 8'd13, 8'd110, 8'd144, 8'd180,
    8'd237, 8'd19, 8'd141
  };

  typedef struct packed {
    logic [63:0] data_low;
    logic [63:0] data_high;
    logic [4:0]  nbytes;
    logic        last_word;
  } sxh_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sxh_qstat_t;

  typedef struct packed {
    logic pop;
    logic load;
  } sxh_bstat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } sxh_state_t;

  typedef enum logic [1:0] {
    PH_DATA,
    PH_FILL,
    PH_COUNT,
    PH_TAIL
  } sxh_phase_t;

  function automatic logic [63:0] sxh_rotl64(input logic [63:0] x, input int unsigned r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic logic [63:0] sxh_sub_rev(input logic [63:0] x);
    logic [63:0] y;
    for (int i = 0; i < 8; i++) begin
      y[8*(7-i) +: 8] = SXH_SBOX[x[8*i +: 8]];
    end
    return y;
  endfunction

  // State is {high, low}.
  function automatic logic [127:0] sxh_round(input logic [127:0] s);
    logic [63:0]  hi;
    logic [63:0]  lo;
    logic [127:0] t;
    hi = sxh_sub_rev(s[63:0]);
    lo = sxh_sub_rev(s[127:64]);
    hi = hi ^ sxh_rotl64(lo, SXH_ROT_A);
    lo = lo ^ sxh_rotl64(hi, SXH_ROT_B);
    t  = {hi, lo};
    return (t << SXH_ROT_C) | (t >> (128 - SXH_ROT_C));
  endfunction

endpackage

>>> hw/rtl/sxh_if.sv
// Valid/ready channel interfaces for message words and hash results.
interface sxh_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_low;
  logic [63:0] data_high;
  logic [4:0]  valid_bytes;
  logic        last_word;

  modport source (output valid, data_low, data_high, valid_bytes, last_word, input ready);
  modport sink (input valid, data_low, data_high, valid_bytes, last_word, output ready);
endinterface

interface sxh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_high;
  logic [63:0] hash_low;

  modport source (output valid, hash_high, hash_low, input ready);
  modport sink (input valid, hash_high, hash_low, output ready);
endinterface

>>> hw/rtl/sbox_xorshift_hash128.sv
// Top level of the sbox xorshift 128-bit hash: queue front end and round back end.
// Each word with nonzero bytes runs ROUND_COUNT rounds, one round a cycle in a single
// shared round unit; an empty non-last word is consumed without running rounds.
// Last word: adds ROUND_COUNT rounds per padding word (up to BLOCK_WORDS + 1 words),
// then loads the result register; a 2-entry queue accepts words meanwhile.
// Reset (rst_n low, synchronous) clears hash state, counters, queue and result valid.
`include "sbox_xorshift_hash128_defines.svh"

module sbox_xorshift_hash128
  import sxh_pkg::*;
#(
  parameter int unsigned BLOCK_WORDS = 64,
  parameter int unsigned ROUND_COUNT = 10
) (
  input  logic      clk,
  input  logic      rst_n,
  sxh_in_if.sink    in_ch,
  sxh_out_if.source out_ch
);

  logic       q_valid;
  logic       q_ready;
  sxh_word_t  q_word;
  sxh_qstat_t qstat;
  sxh_bstat_t bstat;

  sxh_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_word  (q_word),
    .qstat   (qstat)
  );

  sxh_back #(
    .BLOCK_WORDS (BLOCK_WORDS),
    .ROUND_COUNT (ROUND_COUNT)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_word  (q_word),
    .out_ch  (out_ch),
    .bstat   (bstat)
  );

  `SXH_ASSERT_IMP(a_queue_consistent, 1'b1, !(qstat.full && qstat.empty))
  `SXH_ASSERT_IMP(a_pop_nonempty, bstat.pop, !qstat.empty)
  `SXH_ASSERT_IMP(a_no_result_overwrite, bstat.load, !out_ch.valid || out_ch.ready)
  `SXH_ASSERT_NXT(a_load_shows_result, bstat.load, out_ch.valid)

endmodule

>>> hw/rtl/sxh_front.sv
// Front end: byte masking of incoming words and a two-entry word queue.
module sxh_front
  import sxh_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  sxh_in_if.sink     in_ch,
  output logic       q_valid,
  input  logic       q_ready,
  output sxh_word_t  q_word,
  output sxh_qstat_t qstat
);

  localparam int unsigned QD = 2;
  localparam int unsigned PW = $clog2(QD);
  localparam int unsigned CW = $clog2(QD + 1);

  sxh_word_t   mem_r [QD];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic [4:0]  nb;
  sxh_word_t   w_in;
  logic        push, pop;

  always_comb begin
    nb = (in_ch.valid_bytes > SXH_WORD_BYTES) ? SXH_WORD_BYTES : in_ch.valid_bytes;
    w_in.nbytes    = nb;
    w_in.last_word = in_ch.last_word;
    for (int i = 0; i < 8; i++) begin
      w_in.data_low[8*i +: 8]  = (5'(i) < nb) ? in_ch.data_low[8*i +: 8] : 8'h00;
      w_in.data_high[8*i +: 8] = (5'(i + 8) < nb) ? in_ch.data_high[8*i +: 8] : 8'h00;
    end
  end

  assign in_ch.ready = (cnt_r != CW'(QD));
  assign q_valid     = (cnt_r != '0);
  assign q_word      = mem_r[rd_ptr_r];
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = q_valid && q_ready;
  assign qstat.full  = (cnt_r == CW'(QD));
  assign qstat.empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QD - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QD - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= w_in;
    end
  end

endmodule

>>> hw/rtl/sxh_back.sv
// Back end: round engine, padding sequencer and result register.
module sxh_back
  import sxh_pkg::*;
#(
  parameter int unsigned BLOCK_WORDS = 64,
  parameter int unsigned ROUND_COUNT = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  output logic       q_ready,
  input  sxh_word_t  q_word,
  sxh_out_if.source  out_ch,
  output sxh_bstat_t bstat
);

  localparam int unsigned WIB_W = $clog2(BLOCK_WORDS);
  localparam int unsigned RC_W  = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
  localparam logic [WIB_W-1:0] CNT_SLOT = WIB_W'(BLOCK_WORDS - 2);
  localparam logic [WIB_W-1:0] WIB_MAX  = WIB_W'(BLOCK_WORDS - 1);
  localparam logic [RC_W-1:0]  RND_MAX  = RC_W'(ROUND_COUNT - 1);

  sxh_state_t       st_r, st_nxt;
  sxh_phase_t       phase_r, phase_nxt;
  logic [RC_W-1:0]  rnd_r, rnd_nxt;
  logic [WIB_W-1:0] wib_r, wib_nxt;
  logic [63:0]      total_r, total_nxt;
  logic [127:0]     state_r, state_nxt;
  logic [127:0]     inj_r, inj_nxt;
  logic             last_r, last_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [127:0]     hash_r, hash_nxt;

  logic [127:0]     round_in, round_out;
  logic             rnd_end, out_free, pop, load;
  logic [WIB_W-1:0] wib_inc, pad_pos;

  assign round_in  = state_r ^ ((rnd_r == '0) ? inj_r : '0);
  assign round_out = sxh_round(round_in);
  assign rnd_end   = (rnd_r == RND_MAX);
  assign wib_inc   = (wib_r == WIB_MAX) ? '0 : wib_r + 1'b1;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign pop       = (st_r == ST_IDLE) && q_valid;
  assign load      = (st_r == ST_OUT) && out_free;
  assign pad_pos   = (st_r == ST_IDLE) ? wib_r : wib_inc;

  assign q_ready          = (st_r == ST_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.hash_high = hash_r[127:64];
  assign out_ch.hash_low  = hash_r[63:0];
  assign bstat.pop        = pop;
  assign bstat.load       = load;

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (q_valid && ((q_word.nbytes != '0) || q_word.last_word)) begin
          st_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (rnd_end && (phase_r == PH_TAIL)) begin
          st_nxt = ST_OUT;
        end else if (rnd_end && (phase_r == PH_DATA) && !last_r) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    phase_nxt = phase_r;
    rnd_nxt   = rnd_r;
    wib_nxt   = wib_r;
    total_nxt = total_r;
    state_nxt = state_r;
    inj_nxt   = inj_r;
    last_nxt  = last_r;
    hash_nxt  = hash_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;
    unique case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          last_nxt = q_word.last_word;
          rnd_nxt  = '0;
          if (q_word.nbytes != '0) begin
            total_nxt = total_r + 64'(q_word.nbytes);
            inj_nxt   = {q_word.data_high, q_word.data_low};
            phase_nxt = PH_DATA;
          end else if (pad_pos != CNT_SLOT) begin
            inj_nxt   = '0;
            phase_nxt = PH_FILL;
          end else begin
            inj_nxt   = {64'd0, total_r};
            phase_nxt = PH_COUNT;
          end
        end
      end
      ST_RUN: begin
        state_nxt = round_out;
        rnd_nxt   = rnd_end ? '0 : rnd_r + 1'b1;
        if (rnd_end) begin
          wib_nxt = wib_inc;
          unique case (phase_r)
            PH_DATA, PH_FILL: begin
              if ((phase_r == PH_FILL) || last_r) begin
                if (pad_pos != CNT_SLOT) begin
                  inj_nxt   = '0;
                  phase_nxt = PH_FILL;
                end else begin
                  inj_nxt   = {64'd0, total_r};
                  phase_nxt = PH_COUNT;
                end
              end
            end
            PH_COUNT: begin
              inj_nxt   = '0;
              phase_nxt = PH_TAIL;
            end
            PH_TAIL: begin
              phase_nxt = PH_TAIL;
            end
            default: phase_nxt = PH_DATA;
          endcase
        end
      end
      ST_OUT: begin
        if (out_free) begin
          hash_nxt      = state_r;
          out_valid_nxt = 1'b1;
          state_nxt     = '0;
          total_nxt     = '0;
          wib_nxt       = '0;
          phase_nxt     = PH_DATA;
        end
      end
      default: begin
        phase_nxt = PH_DATA;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      phase_r     <= PH_DATA;
      rnd_r       <= '0;
      wib_r       <= '0;
      total_r     <= '0;
      state_r     <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      phase_r     <= phase_nxt;
      rnd_r       <= rnd_nxt;
      wib_r       <= wib_nxt;
      total_r     <= total_nxt;
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    inj_r  <= inj_nxt;
    hash_r <= hash_nxt;
  end

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the sbox xorshift 128-bit hash with a built-in digest predictor.
`timescale 1ns / 100ps

module testbench;
  import sxh_pkg::*;

  localparam int unsigned BLOCK_WORDS   = 64;
  localparam int unsigned ROUND_COUNT   = 10;
  localparam int unsigned WORD_TARGET   = 860;
  localparam int unsigned HOLD_OFF      = 3000;
  localparam int unsigned HOLD_AT       = 6;
  localparam int unsigned DRAIN_CYCLES  = 200;

  class digest_board;
    logic [63:0]  acc_hi;
    logic [63:0]  acc_lo;
    logic [63:0]  byte_count;
    int unsigned  word_pos;
    logic [127:0] digests_due[$];
    int unsigned  mismatches;

    function new();
      clear();
      mismatches = 0;
    endfunction

    function void clear();
      acc_hi     = '0;
      acc_lo     = '0;
      byte_count = '0;
      word_pos   = 0;
    endfunction

    function logic [63:0] sub_rev(logic [63:0] x);
      logic [63:0] y;
      y = '0;
      for (int i = 0; i < 8; i++) begin
        y = {y[55:0], SXH_SBOX[x[8*i +: 8]]};
      end
      return y;
    endfunction

    function void mix_round();
      logic [63:0]  h;
      logic [63:0]  l;
      logic [127:0] t;
      h = sub_rev(acc_lo);
      l = sub_rev(acc_hi);
      h ^= {l[40:0], l[63:41]};
      l ^= {h[46:0], h[63:47]};
      t = {h, l};
      {acc_hi, acc_lo} = {t[80:0], t[127:81]};
    endfunction

    function void absorb(logic [63:0] lo, logic [63:0] hi);
      acc_lo ^= lo;
      acc_hi ^= hi;
      repeat (ROUND_COUNT) mix_round();
      word_pos++;
      if (word_pos >= BLOCK_WORDS) word_pos = 0;
    endfunction

    // Called once per accepted input transaction.
    function void note_word(logic [63:0] lo, logic [63:0] hi, logic [4:0] vb, logic last);
      logic [4:0] nb;
      nb = (vb > 5'd16) ? 5'd16 : vb;
      if (nb != 0) begin
        if (nb < 8) begin
          lo &= (64'd1 << (8 * nb)) - 64'd1;
          hi = '0;
        end else if (nb == 8) begin
          hi = '0;
        end else if (nb < 16) begin
          hi &= (64'd1 << (8 * (nb - 8))) - 64'd1;
        end
        byte_count += 64'(nb);
        absorb(lo, hi);
      end
      if (!last) return;
      // length slot already passed: close this block with zero words
      if (word_pos > BLOCK_WORDS - 2) begin
        while (word_pos != 0) absorb('0, '0);
      end
      while (word_pos < BLOCK_WORDS - 2) absorb('0, '0);
      absorb(byte_count, '0);
      absorb('0, '0);
      digests_due.push_back({acc_hi, acc_lo});
      clear();
    endfunction

    function void check_digest(logic [63:0] hh, logic [63:0] hl);
      logic [127:0] want;
      if (digests_due.size() == 0) begin
        $error("hash result with no digest pending: hash_high=%h hash_low=%h", hh, hl);
        mismatches++;
        return;
      end
      want = digests_due.pop_front();
      if (hh !== want[127:64]) begin
        $error("hash_high mismatch: expected %h, actual %h", want[127:64], hh);
        mismatches++;
      end
      if (hl !== want[63:0]) begin
        $error("hash_low mismatch: expected %h, actual %h", want[63:0], hl);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return digests_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  sxh_in_if  in_if ();
  sxh_out_if out_if ();

  sbox_xorshift_hash128 #(
    .BLOCK_WORDS(BLOCK_WORDS),
    .ROUND_COUNT(ROUND_COUNT)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #6 clk = ~clk;

  digest_board board = new();

  int unsigned words_sent;
  int unsigned messages_sent;
  int unsigned long_messages;
  int unsigned digests_checked;
  bit          send_burst;
  bit          recv_burst;

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_word(input logic [63:0] lo, input logic [63:0] hi,
                           input logic [4:0] vb, input logic last);
    int unsigned gap;
    if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.data_low    <= lo;
    in_if.data_high   <= hi;
    in_if.valid_bytes <= vb;
    in_if.last_word   <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    board.note_word(lo, hi, vb, last);
    if (vb != 0 || last) words_sent++;
    if (last) messages_sent++;
  endtask

  task automatic send_message(input int unsigned len);
    logic [4:0] vb;
    logic       last;
    for (int unsigned i = 0; i < len; i++) begin
      last = (i == len - 1);
      if (last)
        vb = ($urandom_range(0, 3) == 0) ? 5'd16 : 5'($urandom_range(0, 31));
      else
        vb = ($urandom_range(0, 99) < 85) ? 5'd16 : 5'($urandom_range(0, 31));
      send_word(rnd64(), rnd64(), vb, last);
    end
    if (len >= 55) long_messages++;
  endtask

  initial begin
    int unsigned pick;
    words_sent    = 0;
    messages_sent = 0;
    long_messages = 0;
    send_burst    = 1'b0;
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.data_low    <= '0;
    in_if.data_high   <= '0;
    in_if.valid_bytes <= '0;
    in_if.last_word   <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty message, extremes, clamped counts, short and empty words
    send_word(rnd64(), rnd64(), 5'd0, 1'b1);
    send_word('1, '1, 5'd16, 1'b1);
    send_word('1, '1, 5'd31, 1'b1);
    send_word(rnd64(), rnd64(), 5'd17, 1'b1);
    send_word('0, '0, 5'd16, 1'b1);
    send_word('1, '1, 5'd1, 1'b0);
    send_word(rnd64(), rnd64(), 5'd0, 1'b0);
    send_word('1, '1, 5'd7, 1'b1);
    send_word('1, '1, 5'd8, 1'b0);
    send_word('1, '1, 5'd9, 1'b0);
    send_word('1, '1, 5'd15, 1'b0);
    send_word(rnd64(), rnd64(), 5'd0, 1'b1);
    send_word(rnd64(), rnd64(), 5'd5, 1'b0);
    send_word(rnd64(), rnd64(), 5'd24, 1'b1);

    // 63-word message: passes the length slot in the last block when all its words carry bytes
    send_message(63);
    while (words_sent < WORD_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 80)
        send_message($urandom_range(1, 6));
      else if (pick < 93)
        send_message($urandom_range(7, 20));
      else if (pick < 99)
        send_message($urandom_range(55, 70));
      else
        send_message($urandom_range(120, 135));
    end
    in_if.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb: %0d words in %0d messages (%0d long), %0d hash results checked",
             words_sent, messages_sent, long_messages, digests_checked);
    $display("tb: covered empty, short, clamped and multi-block messages with stalls");
    if (board.mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // result side; one long hold-off lets the input queue fill up
  initial begin
    int unsigned stall;
    digests_checked = 0;
    recv_burst      = 1'b0;
    out_if.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
      if (digests_checked == HOLD_AT)
        stall = HOLD_OFF;
      else
        stall = recv_burst ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
      board.check_digest(out_if.hash_high, out_if.hash_low);
      digests_checked++;
    end
  end

  initial begin
    #100_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> sbox_xorshift_hash128.f
+incdir+hw/rtl
hw/rtl/sxh_pkg.sv
hw/rtl/sxh_if.sv
hw/rtl/sxh_front.sv
hw/rtl/sxh_back.sv
hw/rtl/sbox_xorshift_hash128.sv
dv/testbench.sv
